// File: sv/sfsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack frame slot allocator package
// Shared widths, codes, the slot entry layout and the controller interface.
// ----------------------------------------------------------------------------
package sfsa_pkg;

  localparam int ENTRIES      = 32;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int KIND_W       = 3;
  localparam int KEY_W        = 16;
  localparam int SIZE_W       = 12;
  localparam int POP_W        = 6;
  localparam int STATUS_W     = 3;
  localparam int OFF_W        = 21;
  localparam int USED_W       = 6;
  localparam int EXT_W        = OFF_W + 2;
  localparam int BOTTOM_START = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIND        = 3'd0,
    KIND_ALLOC_LOCAL = 3'd1,
    KIND_ALLOC_ARG   = 3'd2,
    KIND_DEALLOC     = 3'd3,
    KIND_SET_PARAM   = 3'd4,
    KIND_CLEAN       = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_TOO_BIG   = 3'd4,
    ST_PARAM_POP = 3'd5,
    ST_OVERFLOW  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FETCH,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [SIZE_W-1:0]       size;
    logic signed [OFF_W-1:0] off;
    logic                    anon;
  } slot_t;

  typedef struct packed {
    logic load;
    logic search;
    logic rd_issue;
    logic rd_first;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic hit;
    logic pend;
    logic more;
    logic pop_fetch;
    logic out_free;
  } ctl_sts_t;

endpackage

// File: sv/sfsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/sfsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator controller
// Sequences accept, table search, slot fetch and result commit.
// ----------------------------------------------------------------------------
module sfsa_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [sfsa_pkg::KIND_W-1:0]    in_kind,
  output logic                           in_stall,
  input  sfsa_pkg::ctl_sts_t             sts,
  output sfsa_pkg::ctl_cmd_t             cmd
);
  import sfsa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (kind_t'(in_kind))
            KIND_FIND, KIND_ALLOC_LOCAL: state_nxt = S_SEARCH;
            KIND_DEALLOC: state_nxt = sts.pop_fetch ? S_FETCH : S_COMMIT;
            default: state_nxt = S_COMMIT;
          endcase
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.hit) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.rd_issue = sts.more;
          if (!sts.pend && !sts.more) begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_FETCH: begin
        cmd.rd_first = 1'b1;
        state_nxt    = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: sv/sfsa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Item registers, frame marks, slot table, search compare and result register.
// ----------------------------------------------------------------------------
module sfsa_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [sfsa_pkg::KIND_W-1:0]         in_kind,
  input  logic [sfsa_pkg::KEY_W-1:0]          in_name_key,
  input  logic [sfsa_pkg::SIZE_W-1:0]         in_size_slots,
  input  logic [sfsa_pkg::POP_W-1:0]          in_pop_count,
  input  sfsa_pkg::ctl_cmd_t                  cmd,
  output sfsa_pkg::ctl_sts_t                  sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sfsa_pkg::STATUS_W-1:0]       out_status,
  output logic signed [sfsa_pkg::OFF_W-1:0]   out_slot_offset,
  output logic [sfsa_pkg::SIZE_W-1:0]         out_slot_size,
  output logic [sfsa_pkg::USED_W-1:0]         out_entries_used
);
  import sfsa_pkg::*;

  localparam logic signed [EXT_W-1:0] OFF_MIN_X = -(EXT_W'(1) <<< (OFF_W - 1));
  localparam logic signed [EXT_W-1:0] OFF_MAX_X = (EXT_W'(1) <<< (OFF_W - 1)) - EXT_W'(1);
  localparam logic signed [OFF_W-1:0] OFF_MAX_N = (OFF_W'(1) <<< (OFF_W - 1)) - OFF_W'(1);

  logic [KIND_W-1:0]        kind_r;
  logic [KEY_W-1:0]         key_r;
  logic [SIZE_W-1:0]        size_r;
  logic [POP_W-1:0]         pop_r;

  logic [USED_W-1:0]        held_r, held_nxt;
  logic signed [OFF_W-1:0]  top_r, top_nxt;
  logic signed [OFF_W-1:0]  bot_r, bot_nxt;
  logic [USED_W-1:0]        idx_r;
  logic                     pend_r;
  logic                     found_r;
  logic signed [OFF_W-1:0]  found_off_r;
  logic [SIZE_W-1:0]        found_size_r;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic signed [OFF_W-1:0]  off_r, off_nxt;
  logic [SIZE_W-1:0]        osize_r, osize_nxt;

  slot_t                    rd_slot;
  slot_t                    wr_slot;
  logic [$bits(slot_t)-1:0] rd_bits;
  logic                     we;
  logic                     re;
  logic [IDX_W-1:0]         raddr;
  logic [USED_W-1:0]        first_w;
  logic                     hit;
  logic                     full;

  logic signed [EXT_W-1:0]  size8_x;
  logic signed [EXT_W-1:0]  noff_x;
  logic signed [EXT_W-1:0]  restored_x;
  logic signed [EXT_W-1:0]  nb_x;

  assign rd_slot = slot_t'(rd_bits);
  assign first_w = held_r - pop_r;
  assign re      = cmd.rd_issue | cmd.rd_first;
  assign raddr   = cmd.rd_issue ? idx_r[IDX_W-1:0] : first_w[IDX_W-1:0];
  assign hit     = pend_r && !rd_slot.anon && (rd_slot.key == key_r);
  assign full    = (held_r >= USED_W'(ENTRIES));

  assign sts.hit       = hit;
  assign sts.pend      = pend_r;
  assign sts.more      = (idx_r < held_r);
  assign sts.pop_fetch = (in_pop_count != '0) && (in_pop_count <= held_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  sfsa_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (held_r[IDX_W-1:0]),
    .wdata (wr_slot),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_bits)
  );

  always_comb begin
    size8_x    = $signed({{(EXT_W - SIZE_W - 3){1'b0}}, size_r, 3'b000});
    noff_x     = $signed({{2{top_r[OFF_W-1]}}, top_r}) - size8_x;
    restored_x = $signed({{2{rd_slot.off[OFF_W-1]}}, rd_slot.off}) +
                 $signed({{(EXT_W - SIZE_W - 3){1'b0}}, rd_slot.size, 3'b000});
    nb_x       = $signed({{2{bot_r[OFF_W-1]}}, bot_r}) +
                 $signed({{(EXT_W - SIZE_W){1'b0}}, size_r});

    held_nxt   = held_r;
    top_nxt    = top_r;
    bot_nxt    = bot_r;
    status_nxt = ST_OK;
    off_nxt    = '0;
    osize_nxt  = '0;
    we         = 1'b0;
    wr_slot.key  = (kind_r == KIND_ALLOC_ARG) ? '0 : key_r;
    wr_slot.size = size_r;
    wr_slot.off  = noff_x[OFF_W-1:0];
    wr_slot.anon = (kind_r == KIND_ALLOC_ARG);

    case (kind_r)
      KIND_FIND: begin
        if (found_r) begin
          off_nxt   = found_off_r;
          osize_nxt = found_size_r;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      KIND_ALLOC_LOCAL, KIND_ALLOC_ARG: begin
        if (kind_r == KIND_ALLOC_LOCAL && found_r) begin
          status_nxt = ST_DUPLICATE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else if (noff_x < OFF_MIN_X) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          we       = cmd.commit;
          held_nxt = held_r + USED_W'(1);
          top_nxt  = noff_x[OFF_W-1:0];
          off_nxt  = noff_x[OFF_W-1:0];
        end
      end
      KIND_DEALLOC: begin
        if (pop_r == '0) begin
          status_nxt = ST_OK;
        end else if (pop_r > held_r) begin
          status_nxt = ST_TOO_BIG;
        end else if (rd_slot.off > $signed(OFF_W'(0))) begin
          status_nxt = ST_PARAM_POP;
        end else begin
          held_nxt = first_w;
          top_nxt  = (restored_x > OFF_MAX_X) ? OFF_MAX_N : restored_x[OFF_W-1:0];
        end
      end
      KIND_SET_PARAM: begin
        wr_slot.key  = key_r;
        wr_slot.off  = bot_r;
        wr_slot.anon = 1'b0;
        if (full) begin
          status_nxt = ST_FULL;
        end else if (nb_x > OFF_MAX_X) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          we       = cmd.commit;
          held_nxt = held_r + USED_W'(1);
          off_nxt  = bot_r;
          bot_nxt  = nb_x[OFF_W-1:0];
        end
      end
      KIND_CLEAN: begin
        held_nxt = '0;
        top_nxt  = '0;
        bot_nxt  = OFF_W'(BOTTOM_START);
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      top_r       <= '0;
      bot_r       <= OFF_W'(BOTTOM_START);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      pend_r <= cmd.rd_issue;
      if (cmd.load) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else if (cmd.rd_issue) begin
        idx_r <= idx_r + USED_W'(1);
      end
      if (cmd.search && hit) begin
        found_r <= 1'b1;
      end
      if (cmd.commit) begin
        held_r      <= held_nxt;
        top_r       <= top_nxt;
        bot_r       <= bot_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      key_r  <= in_name_key;
      size_r <= in_size_slots;
      pop_r  <= in_pop_count;
    end
    if (cmd.search && hit) begin
      found_off_r  <= rd_slot.off;
      found_size_r <= rd_slot.size;
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      off_r    <= off_nxt;
      osize_r  <= osize_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_slot_offset  = off_r;
  assign out_slot_size    = osize_r;
  assign out_entries_used = held_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= USED_W'(ENTRIES))
    else $error("Slot count exceeds table depth.");

  a_bottom_floor: assert property (@(posedge clk) disable iff (!rst_n)
    bot_r >= $signed(OFF_W'(BOTTOM_START)))
    else $error("Bottom mark fell below its start value.");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("Committed item did not reach the result register.");

  a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (idx_r < held_r))
    else $error("Search read beyond the held slots.");

endmodule

// File: sv/stack_frame_slot_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack frame slot allocator
// Table of named frame slots with find, allocate, deallocate and clean.
// ----------------------------------------------------------------------------
// One item is handled at a time. Allocate argument, set parameter, clean, the
// unused kinds and deallocate with a zero or oversized count go straight from
// acceptance to the result commit; any other deallocate first reads the first
// popped slot. Find and allocate local scan the single-read-port slot table
// one entry per cycle, up to the held slots of a full table of 32; a hit ends
// the scan early. A stalled previous result holds back the commit. The next
// item can be accepted while the result is in the output register, even while
// it is still stalled. No clearing pass follows reset.
module stack_frame_slot_allocator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sfsa_pkg::KIND_W-1:0]         in_kind,
  input  logic [sfsa_pkg::KEY_W-1:0]          in_name_key,
  input  logic [sfsa_pkg::SIZE_W-1:0]         in_size_slots,
  input  logic [sfsa_pkg::POP_W-1:0]          in_pop_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sfsa_pkg::STATUS_W-1:0]       out_status,
  output logic signed [sfsa_pkg::OFF_W-1:0]   out_slot_offset,
  output logic [sfsa_pkg::SIZE_W-1:0]         out_slot_size,
  output logic [sfsa_pkg::USED_W-1:0]         out_entries_used
);
  import sfsa_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  sfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfsa_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_kind),
    .in_name_key      (in_name_key),
    .in_size_slots    (in_size_slots),
    .in_pop_count     (in_pop_count),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot_offset  (out_slot_offset),
    .out_slot_size    (out_slot_size),
    .out_entries_used (out_entries_used)
  );

endmodule

// File: sim/sfsa_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack frame slot allocator checker
// Watches both channels of the allocator. Every accepted item runs through a
// local model of the slot table and marks, and the result it predicts is
// queued. Every accepted result is compared field by field with the oldest
// queued prediction. Mismatches and results nobody asked for are counted.
// ----------------------------------------------------------------------------
module sfsa_frame_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [sfsa_pkg::KIND_W-1:0]       in_kind,
  input  logic [sfsa_pkg::KEY_W-1:0]        in_name_key,
  input  logic [sfsa_pkg::SIZE_W-1:0]       in_size_slots,
  input  logic [sfsa_pkg::POP_W-1:0]        in_pop_count,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [sfsa_pkg::STATUS_W-1:0]     out_status,
  input  logic signed [sfsa_pkg::OFF_W-1:0] out_slot_offset,
  input  logic [sfsa_pkg::SIZE_W-1:0]       out_slot_size,
  input  logic [sfsa_pkg::USED_W-1:0]       out_entries_used,
  output int                                fail_count,
  output int                                pending
);
  import sfsa_pkg::*;

  localparam int OFF_LOW  = -1048576;
  localparam int OFF_HIGH = 1048575;

  typedef struct packed {
    status_t                 status;
    logic signed [OFF_W-1:0] off;
    logic [SIZE_W-1:0]       size;
    logic [USED_W-1:0]       used;
  } frame_result_t;

  slot_t         frame_slots [ENTRIES];
  int            slots_held;
  int            top_mark;
  int            bottom_mark;
  frame_result_t frame_results_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int find_slot(logic [KEY_W-1:0] key);
    for (int i = 0; i < slots_held; i++) begin
      if (!frame_slots[i].anon && frame_slots[i].key == key) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void place_slot(logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size,
                                     int off, logic anon);
    frame_slots[slots_held].key  = key;
    frame_slots[slots_held].size = size;
    frame_slots[slots_held].off  = off[OFF_W-1:0];
    frame_slots[slots_held].anon = anon;
    slots_held++;
  endfunction

  function automatic frame_result_t frame_predict(logic [KIND_W-1:0] kind,
                                                  logic [KEY_W-1:0] key,
                                                  logic [SIZE_W-1:0] size,
                                                  logic [POP_W-1:0] cnt);
    frame_result_t r;
    int            idx;
    int            noff;
    int            first;
    int            restored;
    r.status = ST_OK;
    r.off    = '0;
    r.size   = '0;
    case (kind)
      KIND_FIND: begin
        idx = find_slot(key);
        if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.off  = frame_slots[idx].off;
          r.size = frame_slots[idx].size;
        end
      end
      KIND_ALLOC_LOCAL, KIND_ALLOC_ARG: begin
        noff = top_mark - int'(size) * 8;
        if (kind == KIND_ALLOC_LOCAL && find_slot(key) >= 0) begin
          r.status = ST_DUPLICATE;
        end else if (slots_held >= ENTRIES) begin
          r.status = ST_FULL;
        end else if (noff < OFF_LOW) begin
          r.status = ST_OVERFLOW;
        end else begin
          place_slot((kind == KIND_ALLOC_LOCAL) ? key : '0, size, noff,
                     kind == KIND_ALLOC_ARG);
          top_mark = noff;
          r.off    = noff[OFF_W-1:0];
        end
      end
      KIND_DEALLOC: begin
        if (cnt != 0) begin
          if (int'(cnt) > slots_held) begin
            r.status = ST_TOO_BIG;
          end else begin
            first = slots_held - int'(cnt);
            if (frame_slots[first].off > 0) begin
              r.status = ST_PARAM_POP;
            end else begin
              restored = int'(frame_slots[first].off) + int'(frame_slots[first].size) * 8;
              if (restored > OFF_HIGH) begin
                restored = OFF_HIGH;
              end
              slots_held = first;
              top_mark   = restored;
            end
          end
        end
      end
      KIND_SET_PARAM: begin
        noff = bottom_mark + int'(size);
        if (slots_held >= ENTRIES) begin
          r.status = ST_FULL;
        end else if (noff > OFF_HIGH) begin
          r.status = ST_OVERFLOW;
        end else begin
          place_slot(key, size, bottom_mark, 1'b0);
          r.off       = bottom_mark[OFF_W-1:0];
          bottom_mark = noff;
        end
      end
      KIND_CLEAN: begin
        slots_held  = 0;
        top_mark    = 0;
        bottom_mark = BOTTOM_START;
      end
      default: begin
      end
    endcase
    r.used = slots_held[USED_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    frame_result_t e;
    if (!rst_n) begin
      slots_held  = 0;
      top_mark    = 0;
      bottom_mark = BOTTOM_START;
      frame_results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: status %0d offset %0d size %0d used %0d",
                     out_status, out_slot_offset, out_slot_size, out_entries_used);
          end
        end else begin
          e = frame_results_due.pop_front();
          if (out_status !== e.status || out_slot_offset !== e.off ||
              out_slot_size !== e.size || out_entries_used !== e.used) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected status %0d offset %0d size %0d used %0d",
                       e.status, e.off, e.size, e.used);
              $display("          actual   status %0d offset %0d size %0d used %0d",
                       out_status, out_slot_offset, out_slot_size, out_entries_used);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        frame_results_due.push_back(frame_predict(in_kind, in_name_key, in_size_slots,
                                                  in_pop_count));
      end
    end
    pending = frame_results_due.size();
  end

endmodule

// File: sim/tb_stack_frame_slot_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack frame slot allocator testbench
// Drives directed corner cases, a long climb of the parameter mark through
// full tables, and a random mix of frame operations over a small key pool.
// Both sides idle in random bursts, and one long output hold fills the block.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_stack_frame_slot_allocator_top;
  import sfsa_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 440;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [KIND_W-1:0]       in_kind = '0;
  logic [KEY_W-1:0]        in_name_key = '0;
  logic [SIZE_W-1:0]       in_size_slots = '0;
  logic [POP_W-1:0]        in_pop_count = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic signed [OFF_W-1:0] out_slot_offset;
  logic [SIZE_W-1:0]       out_slot_size;
  logic [USED_W-1:0]       out_entries_used;

  logic                    quiet = 1'b0;
  logic                    press_go = 1'b0;
  logic                    hold_on = 1'b0;
  int                      burst_left = 0;
  int                      idle_cycles = 0;
  int                      fail_count;
  int                      pending;
  logic [KEY_W-1:0]        key_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stack_frame_slot_allocator_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_name_key      (in_name_key),
    .in_size_slots    (in_size_slots),
    .in_pop_count     (in_pop_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot_offset  (out_slot_offset),
    .out_slot_size    (out_slot_size),
    .out_entries_used (out_entries_used)
  );

  sfsa_frame_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_name_key      (in_name_key),
    .in_size_slots    (in_size_slots),
    .in_pop_count     (in_pop_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot_offset  (out_slot_offset),
    .out_slot_size    (out_slot_size),
    .out_entries_used (out_entries_used),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      burst_left <= 0;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      burst_left <= $urandom_range(0, 8);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= hold_on;
    end
  end

  // The long hold lets the output register fill so that the block stalls its input.
  initial begin
    while (!press_go) @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("stack_frame_slot_allocator_top regression: fail");
      $finish;
    end
  end

  task automatic send_item(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                           logic [SIZE_W-1:0] size, logic [POP_W-1:0] cnt);
    int gap;
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_name_key   <= key;
    in_size_slots <= size;
    in_pop_count  <= cnt;
    do @(posedge clk); while (in_stall);
    gap = 0;
    if (!quiet && !hold_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic [POP_W-1:0]  cnt;
    int                pick;
    pick = $urandom_range(0, 99);
    key  = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)] : KEY_W'($urandom);
    case ($urandom_range(0, 9))
      0:       size = '0;
      1:       size = '1;
      2, 3:    size = SIZE_W'($urandom);
      default: size = SIZE_W'($urandom_range(1, 16));
    endcase
    cnt = ($urandom_range(0, 9) < 7) ? POP_W'($urandom_range(1, 4))
                                     : POP_W'($urandom_range(0, 32));
    if (pick < 28) begin
      kind = KIND_FIND;
    end else if (pick < 52) begin
      kind = KIND_ALLOC_LOCAL;
    end else if (pick < 62) begin
      kind = KIND_ALLOC_ARG;
    end else if (pick < 77) begin
      kind = KIND_DEALLOC;
    end else if (pick < 89) begin
      kind = KIND_SET_PARAM;
    end else if (pick < 94) begin
      kind = KIND_CLEAN;
    end else if (pick < 96) begin
      kind = ($urandom_range(0, 1) == 0) ? KIND_SPARE_6 : KIND_SPARE_7;
    end else begin
      kind = KIND_FIND;
    end
    send_item(kind, key, size, cnt);
  endtask

  initial begin
    logic [KEY_W-1:0] last_key;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_item(KIND_FIND, 16'h0000, 12'd0, 6'd0);
    send_item(KIND_DEALLOC, 16'h0000, 12'd0, 6'd0);
    send_item(KIND_DEALLOC, 16'h0000, 12'd0, 6'd1);
    send_item(KIND_ALLOC_LOCAL, 16'hFFFF, 12'hFFF, 6'd0);
    send_item(KIND_ALLOC_LOCAL, 16'hFFFF, 12'd1, 6'd0);
    send_item(KIND_ALLOC_LOCAL, 16'h0000, 12'd0, 6'h3F);
    send_item(KIND_FIND, 16'hFFFF, 12'd0, 6'd0);
    send_item(KIND_FIND, 16'h0000, 12'hFFF, 6'd0);
    send_item(KIND_ALLOC_ARG, 16'h1234, 12'd7, 6'd0);
    send_item(KIND_FIND, 16'h1234, 12'd0, 6'd0);
    send_item(KIND_SET_PARAM, 16'hFFFF, 12'hFFF, 6'd0);
    send_item(KIND_SET_PARAM, 16'hABCD, 12'd0, 6'd0);
    send_item(KIND_DEALLOC, 16'h0000, 12'd0, 6'd1);
    send_item(KIND_SPARE_6, 16'hFFFF, 12'hFFF, 6'd1);
    send_item(KIND_SPARE_7, 16'h0000, 12'd0, 6'd2);
    send_item(KIND_FIND, 16'hABCD, 12'd0, 6'd0);
    send_item(KIND_DEALLOC, 16'h0000, 12'd0, 6'd32);
    send_item(KIND_DEALLOC, 16'h0000, 12'd0, 6'd5);
    send_item(KIND_CLEAN, 16'h0000, 12'd0, 6'd0);
    send_item(KIND_SET_PARAM, 16'h0005, 12'd1, 6'd0);
    send_item(KIND_ALLOC_LOCAL, 16'h0006, 12'd2, 6'd0);
    send_item(KIND_DEALLOC, 16'h0000, 12'd0, 6'd2);
    send_item(KIND_CLEAN, 16'h0000, 12'd0, 6'd0);
    send_item(KIND_ALLOC_LOCAL, 16'h0007, 12'd3, 6'd0);
    send_item(KIND_SET_PARAM, 16'h0008, 12'd2, 6'd0);
    send_item(KIND_DEALLOC, 16'h0000, 12'd0, 6'd2);
    send_item(KIND_FIND, 16'h0008, 12'd0, 6'd0);

    // Parameters popped along with a leading argument leave the bottom mark
    // where it was, so repeated full frames push it into overflow.
    send_item(KIND_CLEAN, 16'h0000, 12'd0, 6'd0);
    for (int f = 0; f < 9; f++) begin
      last_key = 16'h0000;
      send_item(KIND_ALLOC_ARG, KEY_W'($urandom), SIZE_W'($urandom), 6'd0);
      for (int p = 0; p < ENTRIES - 1; p++) begin
        last_key = KEY_W'($urandom);
        send_item(KIND_SET_PARAM, last_key, 12'hFFF, 6'd0);
      end
      send_item(KIND_SET_PARAM, KEY_W'($urandom), 12'hFFF, 6'd0);
      send_item(KIND_ALLOC_LOCAL, KEY_W'($urandom), 12'd1, 6'd0);
      send_item(KIND_ALLOC_LOCAL, last_key, 12'd1, 6'd0);
      send_item(KIND_FIND, last_key, 12'd0, 6'd0);
      send_item(KIND_DEALLOC, 16'h0000, 12'd0, 6'd32);
    end
    send_item(KIND_CLEAN, 16'h0000, 12'd0, 6'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom);
      end
      if (n == 250) begin
        press_go <= 1'b1;
      end
      if (n == RANDOM_ITEMS - 100) begin
        quiet <= 1'b1;
      end
      send_random_item();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("stack_frame_slot_allocator_top regression: pass");
    end else begin
      $display("stack_frame_slot_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
